>>> rtl/int_to_ascii_formatter_core_assert.svh
// Assertion macros for the integer-to-ASCII formatter checker.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef INT_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define INT_TO_ASCII_FORMATTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2A_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2A_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/i2a_pkg.sv
// Shared constants, types and helper functions for the integer-to-ASCII formatter.
// No dependencies.
package i2a_pkg;

	localparam int VALUE_BITS_DEF = 32;

	localparam logic [6:0] CH_ZERO    = 7'h30;
	localparam logic [6:0] CH_UPPER_A = 7'h41;
	localparam logic [6:0] CH_MINUS   = 7'h2D;
	localparam logic [6:0] CH_LOWER_X = 7'h78;

	localparam logic MODE_DEC = 1'b0;
	localparam logic MODE_HEX = 1'b1;

	typedef enum logic [2:0] {
		DU_HOLD,
		DU_LOAD_DEC,
		DU_LOAD_HEX,
		DU_STEP,
		DU_SHIFT
	} du_cmd_t;

	// Decimal digits needed for an unsigned value of the given width.
	function automatic int dec_digits(int bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

	function automatic logic [6:0] digit_char(logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + 7'(d);
		end else begin
			c = CH_UPPER_A + 7'(d) - 7'd10;
		end
		return c;
	endfunction

endpackage

>>> rtl/i2a_if.sv
// Valid/ready channel interfaces for the integer-to-ASCII formatter.
// Depends on i2a_pkg.
interface i2a_in_if #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;
	logic                         mode;

	modport source (output valid, value, mode, input ready);
	modport sink (input valid, value, mode, output ready);
endinterface

interface i2a_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] character;
	logic       last;

	modport source (output valid, character, last, input ready);
	modport sink (input valid, character, last, output ready);
endinterface

>>> rtl/i2a_digit_unit.sv
// Shared digit unit: double-dabble binary to BCD, one bit per step, and a
// four-bit left shifter that presents the leading digit. Depends on i2a_pkg.
module i2a_digit_unit #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF,
	parameter int NUM_DIGITS = i2a_pkg::dec_digits(i2a_pkg::VALUE_BITS_DEF)
) (
	input  logic                  clk,
	input  i2a_pkg::du_cmd_t      cmd,
	input  logic [VALUE_BITS-1:0] load_val,
	output logic [3:0]            top_digit
);

	localparam int DIG_W = 4 * NUM_DIGITS;

	logic [VALUE_BITS-1:0] bin_q;
	logic [DIG_W-1:0]      bcd_q;
	logic [DIG_W-1:0]      adj;

	always_comb begin
		adj = bcd_q;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			i2a_pkg::DU_LOAD_DEC: begin
				bin_q <= load_val;
				bcd_q <= '0;
			end
			i2a_pkg::DU_LOAD_HEX: begin
				bcd_q <= DIG_W'(load_val);
			end
			i2a_pkg::DU_STEP: begin
				{bcd_q, bin_q} <= {adj, bin_q} << 1;
			end
			i2a_pkg::DU_SHIFT: begin
				bcd_q <= {bcd_q[DIG_W-5:0], 4'h0};
			end
			default: begin
			end
		endcase
	end

	assign top_digit = bcd_q[DIG_W-1 -: 4];

endmodule

>>> rtl/int_to_ascii_formatter_core.sv
// Integer-to-ASCII formatter top level: sequencer, sign handling and output register.
// Depends on i2a_pkg, i2a_if and i2a_digit_unit.
//
// Formats one VALUE_BITS-bit value per transaction as ASCII, most significant
// character first, with last set on the final character. mode 0 prints signed
// decimal with a leading '-' for negative values; mode 1 prints "0x" and the
// uppercase hex digits of the raw bit pattern. Leading zeros are dropped and
// zero prints as a single '0'. One item is in work at a time and item.ready is
// high only when idle. A decimal item runs double-dabble conversion (one bit per
// cycle in the shared digit unit), then emits '-' if negative; a hex item skips
// conversion and emits the "0x" prefix. Both then drop the leading zeros of the
// digit register and emit the remaining digits; a result stall holds emission.
module int_to_ascii_formatter_core #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	i2a_in_if.sink    item,
	i2a_out_if.source result
);

	localparam int NUM_DIGITS = i2a_pkg::dec_digits(VALUE_BITS);
	localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
	localparam int STEP_W     = $clog2(VALUE_BITS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_PFX,
		S_PFX_X,
		S_SKIP,
		S_EMIT
	} state_t;

	state_t                state_q;
	logic                  hex_q;
	logic                  neg_q;
	logic [STEP_W-1:0]     step_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  ovld_q;
	logic [6:0]            char_q;
	logic                  last_q;

	logic                  accept;
	logic                  slot_free;
	logic                  load_char;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic [VALUE_BITS-1:0] load_val;
	logic [3:0]            top_digit;
	logic                  lead_zero;
	i2a_pkg::du_cmd_t      du_cmd;

	assign accept    = item.valid && item.ready;
	assign slot_free = !ovld_q || result.ready;
	assign load_char = slot_free &&
		(state_q == S_PFX || state_q == S_PFX_X || state_q == S_EMIT);
	assign raw       = item.value;
	assign mag       = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
	assign load_val  = (item.mode == i2a_pkg::MODE_HEX) ? raw : mag;
	assign lead_zero = (top_digit == 4'h0) && (cnt_q > CNT_W'(1));

	always_comb begin
		du_cmd = i2a_pkg::DU_HOLD;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					du_cmd = (item.mode == i2a_pkg::MODE_HEX) ?
						i2a_pkg::DU_LOAD_HEX : i2a_pkg::DU_LOAD_DEC;
				end
			end
			S_CONV: du_cmd = i2a_pkg::DU_STEP;
			S_SKIP: begin
				if (lead_zero) begin
					du_cmd = i2a_pkg::DU_SHIFT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					du_cmd = i2a_pkg::DU_SHIFT;
				end
			end
			default: du_cmd = i2a_pkg::DU_HOLD;
		endcase
	end

	i2a_digit_unit #(
		.VALUE_BITS (VALUE_BITS),
		.NUM_DIGITS (NUM_DIGITS)
	) u_digit (
		.clk       (clk),
		.cmd       (du_cmd),
		.load_val  (load_val),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hex_q   <= 1'b0;
			neg_q   <= 1'b0;
			step_q  <= '0;
			cnt_q   <= '0;
			ovld_q  <= 1'b0;
			char_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			if (load_char) begin
				ovld_q <= 1'b1;
			end else if (result.ready) begin
				ovld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						hex_q   <= (item.mode == i2a_pkg::MODE_HEX);
						neg_q   <= (item.mode == i2a_pkg::MODE_DEC) && raw[VALUE_BITS-1];
						step_q  <= STEP_W'(VALUE_BITS);
						cnt_q   <= CNT_W'(NUM_DIGITS);
						state_q <= (item.mode == i2a_pkg::MODE_HEX) ? S_PFX : S_CONV;
					end
				end
				S_CONV: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == STEP_W'(1)) begin
						state_q <= neg_q ? S_PFX : S_SKIP;
					end
				end
				S_PFX: begin
					if (slot_free) begin
						char_q  <= hex_q ? i2a_pkg::CH_ZERO : i2a_pkg::CH_MINUS;
						last_q  <= 1'b0;
						state_q <= hex_q ? S_PFX_X : S_SKIP;
					end
				end
				S_PFX_X: begin
					if (slot_free) begin
						char_q  <= i2a_pkg::CH_LOWER_X;
						last_q  <= 1'b0;
						state_q <= S_SKIP;
					end
				end
				S_SKIP: begin
					if (lead_zero) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						char_q <= i2a_pkg::digit_char(top_digit);
						last_q <= (cnt_q == CNT_W'(1));
						cnt_q  <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item.ready       = (state_q == S_IDLE);
	assign result.valid     = ovld_q;
	assign result.character = char_q;
	assign result.last      = last_q;

endmodule

>>> rtl/i2a_checker.sv
// Port-level checker for the integer-to-ASCII formatter, bound to the top level.
// Depends on int_to_ascii_formatter_core_assert.svh.
`include "int_to_ascii_formatter_core_assert.svh"

module i2a_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [6:0] result_character,
	input logic       result_last
);

	logic       item_xact;
	logic       result_xact;
	logic       legal_char;
	logic [1:0] pend_q;

	assign item_xact   = item_valid && item_ready;
	assign result_xact = result_valid && result_ready;
	assign legal_char  = (result_character >= 7'h30 && result_character <= 7'h39) ||
		(result_character >= 7'h41 && result_character <= 7'h46) ||
		(result_character == 7'h2D) || (result_character == 7'h78);

	// Count accepted items that still owe their final character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + 2'(item_xact) - 2'(result_xact && result_last);
		end
	end

	`I2A_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_character) && $stable(result_last), "stalled result changed")
	`I2A_ASSERT_NXT(a_busy_after_accept, clk, arst_n, item_xact, !item_ready, "input ready right after a transaction")
	`I2A_ASSERT_IMP(a_legal_char, clk, arst_n, result_valid, legal_char, "illegal character code")
	`I2A_ASSERT_IMP(a_no_orphan_result, clk, arst_n, result_valid, pend_q != 2'd0, "result with no item in work")

endmodule

bind int_to_ascii_formatter_core i2a_checker u_i2a_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item.valid),
	.item_ready       (item.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.result_character (result.character),
	.result_last      (result.last)
);

>>> tb/int_to_ascii_formatter_core_tb.sv
// Testbench for int_to_ascii_formatter_core: directed table of numbers, then random ones.
// Each accepted number is predicted as a character string and checked on the result channel.
// Depends on i2a_pkg, i2a_if and the formatter RTL.
`timescale 1ns / 1ps

module int_to_ascii_formatter_core_tb;

	localparam int VB           = i2a_pkg::VALUE_BITS_DEF;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 100;
	localparam int DRAIN_CYCLES = 64;
	localparam int HOLDOFF_AT   = 300;
	localparam int MAX_REPORTS  = 100;

	typedef byte unsigned char_q_t[$];

	typedef struct {
		logic [6:0] character;
		logic       last;
	} char_t;

	typedef struct {
		logic [VB-1:0] value;
		logic          mode;
		string         text;
	} number_row_t;

	logic clk;
	logic arst_n;

	i2a_in_if #(.VALUE_BITS(VB)) number_in ();
	i2a_out_if char_out ();

	int_to_ascii_formatter_core #(
		.VALUE_BITS(VB)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (number_in),
		.result (char_out)
	);

	char_t pending_chars[$];
	int    mismatches    = 0;
	int    chars_checked = 0;
	int    dec_numbers   = 0;
	int    hex_numbers   = 0;
	bit    holdoff_done  = 0;
	bit    quiet_sender  = 0;

	number_row_t directed_rows [18] = '{
		'{32'h0000_0000, i2a_pkg::MODE_DEC, "0"},
		'{32'h0000_0000, i2a_pkg::MODE_HEX, "0x0"},
		'{32'hFFFF_FFFF, i2a_pkg::MODE_DEC, "-1"},
		'{32'hFFFF_FFFF, i2a_pkg::MODE_HEX, "0xFFFFFFFF"},
		'{32'h7FFF_FFFF, i2a_pkg::MODE_DEC, "2147483647"},
		'{32'h7FFF_FFFF, i2a_pkg::MODE_HEX, "0x7FFFFFFF"},
		'{32'h8000_0000, i2a_pkg::MODE_DEC, "-2147483648"},
		'{32'h8000_0000, i2a_pkg::MODE_HEX, "0x80000000"},
		'{32'd9,         i2a_pkg::MODE_DEC, "9"},
		'{32'd10,        i2a_pkg::MODE_DEC, "10"},
		'{32'd15,        i2a_pkg::MODE_HEX, "0xF"},
		'{32'd16,        i2a_pkg::MODE_HEX, "0x10"},
		'{32'hFFFF_FFF6, i2a_pkg::MODE_DEC, "-10"},
		'{32'hABCD_EF01, i2a_pkg::MODE_HEX, ""},
		'{32'd1000000000, i2a_pkg::MODE_DEC, ""},
		'{32'hC465_3601, i2a_pkg::MODE_DEC, ""},
		'{32'h1234_5678, i2a_pkg::MODE_HEX, ""},
		'{32'h0000_00FF, i2a_pkg::MODE_HEX, ""}
	};

	function automatic char_q_t format_number(logic [VB-1:0] v, logic m);
		char_q_t       text;
		logic [VB-1:0] mag;
		logic [3:0]    nib;
		if (m == i2a_pkg::MODE_HEX) begin
			mag = v;
			do begin
				nib = mag[3:0];
				text.push_front(nib < 4'd10 ? 8'(i2a_pkg::CH_ZERO) + 8'(nib)
				                            : 8'(i2a_pkg::CH_UPPER_A) + 8'(nib) - 8'd10);
				mag = mag >> 4;
			end while (mag != '0);
			text.push_front(8'(i2a_pkg::CH_LOWER_X));
			text.push_front(8'(i2a_pkg::CH_ZERO));
		end else begin
			mag = v[VB-1] ? -v : v;
			do begin
				text.push_front(8'(i2a_pkg::CH_ZERO) + 8'(mag % 10));
				mag = mag / 10;
			end while (mag != '0);
			if (v[VB-1]) begin
				text.push_front(8'(i2a_pkg::CH_MINUS));
			end
		end
		return text;
	endfunction

	function automatic int sender_gap();
		if (quiet_sender || $urandom_range(0, 2) != 0) begin
			return 0;
		end
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
	endfunction

	task automatic send_number(input logic [VB-1:0] v, input logic m, input string typed);
		char_q_t text;
		int      gap;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			number_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		number_in.valid <= 1'b1;
		number_in.value <= v;
		number_in.mode  <= m;
		do @(posedge clk); while (number_in.ready !== 1'b1);
		text = format_number(v, m);
		if (typed.len() != 0) begin
			text.delete();
			for (int i = 0; i < typed.len(); i++) text.push_back(typed[i]);
		end
		for (int i = 0; i < text.size(); i++) begin
			pending_chars.push_back('{character: text[i][6:0], last: (i == text.size() - 1)});
		end
		if (m == i2a_pkg::MODE_HEX) hex_numbers++;
		else dec_numbers++;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout at %0t, %0d characters still pending", $time, pending_chars.size());
		$display("[int_to_ascii_formatter_core] ERROR");
		$finish;
	end

	// result side: random stalls, quiet stretches and one long hold-off
	initial begin
		int hold_cycles;
		hold_cycles = 0;
		char_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				char_out.ready <= 1'b0;
			end else if (!holdoff_done && chars_checked >= HOLDOFF_AT) begin
				holdoff_done = 1;
				hold_cycles  = 299;
				char_out.ready <= 1'b0;
			end else if ((chars_checked / 150) % 3 != 1 && $urandom_range(0, 5) == 0) begin
				hold_cycles = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				                                          : $urandom_range(0, 2);
				char_out.ready <= 1'b0;
			end else begin
				char_out.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_chars
		char_t want;
		if (arst_n && char_out.valid === 1'b1 && char_out.ready === 1'b1) begin
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected character: expected none, got char=%h last=%b",
					         $time, char_out.character, char_out.last);
			end else begin
				want = pending_chars.pop_front();
				chars_checked++;
				if (char_out.character !== want.character || char_out.last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: mismatch: expected char=%h last=%b, got char=%h last=%b",
						         $time, want.character, want.last,
						         char_out.character, char_out.last);
				end
			end
		end
	end

	initial begin
		logic [VB-1:0] v;
		logic          m;
		arst_n          = 1'b0;
		number_in.valid = 1'b0;
		number_in.value = '0;
		number_in.mode  = i2a_pkg::MODE_DEC;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			send_number(directed_rows[i].value, directed_rows[i].mode, directed_rows[i].text);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet_sender = (n >= 40 && n < 55);
			m = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: v = $urandom;
				1: v = $urandom >> $urandom_range(0, 31);
				2: v = -($urandom >> $urandom_range(0, 31));
				default: v = (VB'(1) << $urandom_range(0, VB - 1)) - VB'($urandom_range(0, 1));
			endcase
			send_number(v, m, "");
		end
		@(negedge clk);
		number_in.valid <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("formatted %0d numbers (%0d decimal, %0d hex), %0d characters checked",
		         dec_numbers + hex_numbers, dec_numbers, hex_numbers, chars_checked);
		$display("extremes, zero and digit-count boundaries included; %0d mismatches",
		         mismatches);
		if (mismatches == 0) begin
			$display("[int_to_ascii_formatter_core] OK");
		end else begin
			$display("[int_to_ascii_formatter_core] ERROR");
		end
		$finish;
	end

endmodule
